### rtl/core/qyh_pkg.sv
package qyh_pkg;

    localparam int QW             = 16;   // quaternion component width
    localparam int PW             = 2 * QW;
    localparam int XW             = 38;   // CORDIC x and y width, leaves room for gain
    localparam int ZW             = 26;   // angle accumulator, 2^-16 degree units
    localparam int AW             = 23;   // arctangent table entry width
    localparam int OFFW           = 10;   // mounting correction width
    localparam int TW             = 28;   // angle plus correction plus rounding
    localparam int HW             = TW - 10;
    localparam int OUTW           = 15;
    localparam int ATAN_ROM_SIZE  = 24;
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FIFO_DEPTH     = 4;
    localparam longint Q28_ONE    = 64'd1 << 28;
    localparam longint DEG_90     = 90 * 65536;
    localparam int FULL_TURN_OUT  = 23040;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;   // both terms zero: yaw is forced to 0
    } t_term;

    // atan(2^-i) in degrees, scaled by 65536 and rounded.
    function automatic logic [AW-1:0] atan_lut(input logic [4:0] idx);
        logic [AW-1:0] v;
        unique case (idx)
            5'd0:    v = AW'(2949120);
            5'd1:    v = AW'(1740967);
            5'd2:    v = AW'(919879);
            5'd3:    v = AW'(466945);
            5'd4:    v = AW'(234379);
            5'd5:    v = AW'(117304);
            5'd6:    v = AW'(58666);
            5'd7:    v = AW'(29335);
            5'd8:    v = AW'(14668);
            5'd9:    v = AW'(7334);
            5'd10:   v = AW'(3667);
            5'd11:   v = AW'(1833);
            5'd12:   v = AW'(917);
            5'd13:   v = AW'(458);
            5'd14:   v = AW'(229);
            5'd15:   v = AW'(115);
            5'd16:   v = AW'(57);
            5'd17:   v = AW'(29);
            5'd18:   v = AW'(14);
            5'd19:   v = AW'(7);
            5'd20:   v = AW'(4);
            5'd21:   v = AW'(2);
            5'd22:   v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/qyh_front.sv
module qyh_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [qyh_pkg::QW-1:0]        i_quat_real,
    input  logic signed [qyh_pkg::QW-1:0]        i_quat_i,
    input  logic signed [qyh_pkg::QW-1:0]        i_quat_j,
    input  logic signed [qyh_pkg::QW-1:0]        i_quat_k,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output qyh_pkg::t_term                       o_term
);

    logic                               r_v1, r_v2;
    logic                               rdy1, rdy2;
    logic signed [qyh_pkg::PW-1:0]      r_pjj, r_pkk, r_pij, r_prk;
    logic signed [qyh_pkg::XW-1:0]      c, y0;
    qyh_pkg::t_term                     r_term, n_term;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_term  = r_term;

    // Rotation-matrix terms, exact, then the left half plane is folded over.
    always_comb begin
        c = qyh_pkg::XW'(qyh_pkg::Q28_ONE)
            - ((qyh_pkg::XW'(r_pjj) + qyh_pkg::XW'(r_pkk)) <<< 1);
        y0 = -((qyh_pkg::XW'(r_pij) + qyh_pkg::XW'(r_prk)) <<< 1);
        n_term.zero = (c == '0) && (y0 == '0);
        if (c[qyh_pkg::XW-1] && !y0[qyh_pkg::XW-1]) begin
            n_term.x = y0;
            n_term.y = -c;
            n_term.z = qyh_pkg::ZW'(qyh_pkg::DEG_90);
        end else if (c[qyh_pkg::XW-1]) begin
            n_term.x = -y0;
            n_term.y = c;
            n_term.z = -qyh_pkg::ZW'(qyh_pkg::DEG_90);
        end else begin
            n_term.x = c;
            n_term.y = y0;
            n_term.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_pjj <= i_quat_j * i_quat_j;
            r_pkk <= i_quat_k * i_quat_k;
            r_pij <= i_quat_i * i_quat_j;
            r_prk <= i_quat_real * i_quat_k;
        end
        if (rdy2) r_term <= n_term;
    end

endmodule

### rtl/core/qyh_fifo.sv
module qyh_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qyh_pkg::t_term i_term,
    output logic           o_valid,
    input  logic           i_ready,
    output qyh_pkg::t_term o_term
);

    localparam int PTRW = $clog2(qyh_pkg::FIFO_DEPTH);

    qyh_pkg::t_term    r_mem [qyh_pkg::FIFO_DEPTH];
    logic [PTRW-1:0]   r_wr, r_rd;
    logic [PTRW:0]     r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != (PTRW+1)'(qyh_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_term  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTRW+1)'(push) - (PTRW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_term;
    end

endmodule

### rtl/core/qyh_back.sv
module qyh_back #(
    parameter int CORDIC_ITERATIONS = qyh_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  qyh_pkg::t_term                    i_term,
    input  logic signed [qyh_pkg::OFFW-1:0]   i_offset,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [qyh_pkg::OUTW-1:0]          o_heading
);

    localparam int NIT = (CORDIC_ITERATIONS > qyh_pkg::ATAN_ROM_SIZE) ?
                         qyh_pkg::ATAN_ROM_SIZE : CORDIC_ITERATIONS;
    localparam logic signed [qyh_pkg::HW-1:0] FT = qyh_pkg::HW'(qyh_pkg::FULL_TURN_OUT);

    qyh_pkg::t_term             r_st [NIT];
    qyh_pkg::t_term             st_in [NIT];
    qyh_pkg::t_term             st_nx [NIT];
    logic [NIT-1:0]             r_v, vin;
    logic [NIT:0]               rdy;
    logic                       r_ov;
    logic [qyh_pkg::OUTW-1:0]   r_heading, n_heading;
    logic signed [qyh_pkg::TW-1:0] total;
    logic signed [qyh_pkg::HW-1:0] h;

    assign rdy[NIT]  = !r_ov || i_ready;
    assign o_ready   = rdy[0];
    assign o_valid   = r_ov;
    assign o_heading = r_heading;

    for (genvar k = 0; k < NIT; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign st_in[k] = i_term;
            assign vin[k]   = i_valid;
        end else begin : g_next
            assign st_in[k] = r_st[k-1];
            assign vin[k]   = r_v[k-1];
        end
        assign rdy[k] = !r_v[k] || rdy[k+1];

        // One micro-rotation towards the x axis.
        always_comb begin
            st_nx[k].zero = st_in[k].zero;
            if (!st_in[k].y[qyh_pkg::XW-1]) begin
                st_nx[k].x = st_in[k].x + (st_in[k].y >>> k);
                st_nx[k].y = st_in[k].y - (st_in[k].x >>> k);
                st_nx[k].z = st_in[k].z + qyh_pkg::ZW'(qyh_pkg::atan_lut(5'(k)));
            end else begin
                st_nx[k].x = st_in[k].x - (st_in[k].y >>> k);
                st_nx[k].y = st_in[k].y + (st_in[k].x >>> k);
                st_nx[k].z = st_in[k].z - qyh_pkg::ZW'(qyh_pkg::atan_lut(5'(k)));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) r_st[k] <= st_nx[k];
        end
    end

    // Add the correction, round to 1/64 degree and reduce into one turn.
    always_comb begin
        total = (r_st[NIT-1].zero ? '0 : qyh_pkg::TW'(r_st[NIT-1].z))
                + (qyh_pkg::TW'(i_offset) <<< 16) + qyh_pkg::TW'(512);
        h = qyh_pkg::HW'(total >>> 10);
        priority if (h < -FT) begin
            n_heading = qyh_pkg::OUTW'(h + (FT <<< 1));
        end else if (h < 0) begin
            n_heading = qyh_pkg::OUTW'(h + FT);
        end else if (h < FT) begin
            n_heading = qyh_pkg::OUTW'(h);
        end else begin
            n_heading = qyh_pkg::OUTW'(h - FT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy[NIT]) begin
            r_ov <= r_v[NIT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NIT]) r_heading <= n_heading;
    end

endmodule

### rtl/core/quaternion_yaw_heading.sv
// Yaw heading from an orientation quaternion.
// Input channel: i_valid / o_ready carry one request, a quaternion in signed
// Q14 (i_quat_real, i_quat_i, i_quat_j, i_quat_k). Output channel: o_valid /
// i_ready carry the heading in 1/64 degree, 0 to 23039.
// The mounting correction is written through i_cfg_we / i_cfg_wdata, in whole
// degrees, and should only be changed while no request is in flight.
// The request passes two front stages that form the products and rotation
// terms, one entry of the four-entry queue, one stage per CORDIC
// micro-rotation and a last stage that adds the correction and reduces modulo
// one full turn; the first of these stages is loaded at the accepting edge.
// Throughput is one request per cycle while i_ready stays high; the unrolled CORDIC stage chain sets it.
// When the receiver stalls, results hold in their stages, bubbles close up,
// and o_ready falls once the front stages and the queue are full.
// A synchronous reset empties every stage and clears the correction to zero.
module quaternion_yaw_heading #(
    parameter int CORDIC_ITERATIONS = qyh_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qyh_pkg::OFFW-1:0]          i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [qyh_pkg::QW-1:0]     i_quat_real,
    input  logic signed [qyh_pkg::QW-1:0]     i_quat_i,
    input  logic signed [qyh_pkg::QW-1:0]     i_quat_j,
    input  logic signed [qyh_pkg::QW-1:0]     i_quat_k,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [qyh_pkg::OUTW-1:0]          o_heading
);

    logic signed [qyh_pkg::OFFW-1:0] r_offset;
    logic           f_valid, f_ready, q_valid, q_ready;
    qyh_pkg::t_term f_term, q_term;

    // The correction register, taken as a signed whole-degree value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    qyh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_quat_real (i_quat_real),
        .i_quat_i    (i_quat_i),
        .i_quat_j    (i_quat_j),
        .i_quat_k    (i_quat_k),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_term      (f_term)
    );

    // The queue decouples classification from the CORDIC chain.
    qyh_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_term  (f_term),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_term  (q_term)
    );

    qyh_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_term    (q_term),
        .i_offset  (r_offset),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_heading (o_heading)
    );

endmodule

### rtl/core/qyh_checker.sv
module qyh_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic signed [qyh_pkg::QW-1:0]     i_quat_real,
    input logic signed [qyh_pkg::QW-1:0]     i_quat_i,
    input logic signed [qyh_pkg::QW-1:0]     i_quat_j,
    input logic signed [qyh_pkg::QW-1:0]     i_quat_k,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [qyh_pkg::OUTW-1:0]          o_heading
);

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid
            && $stable({i_quat_real, i_quat_i, i_quat_j, i_quat_k}))
        else $error("request withdrawn or changed while waiting");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_heading))
        else $error("stalled heading changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading < qyh_pkg::OUTW'(qyh_pkg::FULL_TURN_OUT))
        else $error("heading outside one turn");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind quaternion_yaw_heading qyh_checker u_qyh_checker (.*);
